/* rtl/core/roman_enc_pkg.sv */
// Shared types, constants and step tables for the Roman numeral encoder.
package roman_enc_pkg;

    localparam int VALUE_W    = 12;
    localparam int LETTER_W   = 7;
    localparam int STEP_COUNT = 13;
    localparam int STEP_IDX_W = $clog2(STEP_COUNT);

    // ASCII codes of the numeral letters
    localparam logic [LETTER_W-1:0] LETTER_NONE = 7'd0;
    localparam logic [LETTER_W-1:0] LETTER_I    = 7'd73;
    localparam logic [LETTER_W-1:0] LETTER_V    = 7'd86;
    localparam logic [LETTER_W-1:0] LETTER_X    = 7'd88;
    localparam logic [LETTER_W-1:0] LETTER_L    = 7'd76;
    localparam logic [LETTER_W-1:0] LETTER_C    = 7'd67;
    localparam logic [LETTER_W-1:0] LETTER_D    = 7'd68;
    localparam logic [LETTER_W-1:0] LETTER_M    = 7'd77;

    // Greedy steps, largest first
    localparam logic [VALUE_W-1:0] STEP_VALUE [STEP_COUNT] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };

    localparam logic [LETTER_W-1:0] STEP_FIRST [STEP_COUNT] = '{
        LETTER_M, LETTER_C, LETTER_D, LETTER_C, LETTER_C, LETTER_X, LETTER_L,
        LETTER_X, LETTER_X, LETTER_I, LETTER_V, LETTER_I, LETTER_I
    };

    // Second letter of a subtractive pair, LETTER_NONE for single letters
    localparam logic [LETTER_W-1:0] STEP_SECOND [STEP_COUNT] = '{
        LETTER_NONE, LETTER_M, LETTER_NONE, LETTER_D, LETTER_NONE, LETTER_C,
        LETTER_NONE, LETTER_L, LETTER_NONE, LETTER_X, LETTER_NONE, LETTER_V,
        LETTER_NONE
    };

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;  // take a new value
        logic emit;  // form the next output beat
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;  // the beat being formed ends the run
    } dp_status_t;

    // Index of the largest step not above rem (the smallest step if rem is zero)
    function automatic logic [STEP_IDX_W-1:0] step_select(input logic [VALUE_W-1:0] rem);
        logic [STEP_IDX_W-1:0] sel;
        sel = STEP_IDX_W'(STEP_COUNT - 1);
        for (int i = STEP_COUNT - 1; i >= 0; i--) begin
            if (rem >= STEP_VALUE[i])
            begin
                sel = STEP_IDX_W'(i);
            end
        end
        return sel;
    endfunction

endpackage

/* rtl/core/roman_enc_value_if.sv */
// Input channel: one unsigned value per beat.
interface roman_enc_value_if
    import roman_enc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* rtl/core/roman_enc_letter_if.sv */
// Output channel: one numeral letter per beat with run flags.
interface roman_enc_letter_if
    import roman_enc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                last_letter;
    logic                empty_res;

    modport source (output valid, output letter, output last_letter,
                    output empty_res, input ready);
    modport sink   (input valid, input letter, input last_letter,
                    input empty_res, output ready);
endinterface

/* rtl/core/roman_enc_dp.sv */
// Datapath: remainder, pending second letter and the output beat register.
module roman_enc_dp
    import roman_enc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    input  logic [VALUE_W-1:0]  value,
    output dp_status_t          status,
    output logic [LETTER_W-1:0] letter,
    output logic                last_letter,
    output logic                empty_res
);

    logic [VALUE_W-1:0]    remainder_reg, remainder_next;
    logic [LETTER_W-1:0]   pending_reg, pending_next;
    logic [LETTER_W-1:0]   letter_reg, letter_next;
    logic                  last_reg, last_next;
    logic                  empty_reg, empty_next;
    logic [STEP_IDX_W-1:0] sel;
    logic [VALUE_W-1:0]    rem_sub;

    // greedy step choice and subtraction
    assign sel     = step_select(remainder_reg);
    assign rem_sub = remainder_reg - STEP_VALUE[sel];

    // next beat
    always_comb
    begin
        remainder_next = remainder_reg;
        pending_next   = pending_reg;
        letter_next    = letter_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        if (cmd.load)
        begin
            remainder_next = value;
            pending_next   = LETTER_NONE;
        end
        else if (pending_reg != LETTER_NONE)
        begin
            // second letter of a subtractive pair
            letter_next  = pending_reg;
            last_next    = (remainder_reg == '0);
            empty_next   = 1'b0;
            pending_next = LETTER_NONE;
        end
        else if (remainder_reg != '0)
        begin
            letter_next    = STEP_FIRST[sel];
            last_next      = (rem_sub == '0) && (STEP_SECOND[sel] == LETTER_NONE);
            empty_next     = 1'b0;
            remainder_next = rem_sub;
            pending_next   = STEP_SECOND[sel];
        end
        else
        begin
            // zero input: one empty beat
            letter_next = LETTER_NONE;
            last_next   = 1'b1;
            empty_next  = 1'b1;
        end
    end

    assign status.last = last_next;

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remainder_reg <= '0;
            pending_reg   <= LETTER_NONE;
        end
        else if (cmd.load || cmd.emit)
        begin
            remainder_reg <= remainder_next;
            pending_reg   <= pending_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            letter_reg <= letter_next;
            last_reg   <= last_next;
            empty_reg  <= empty_next;
        end
    end

    assign letter      = letter_reg;
    assign last_letter = last_reg;
    assign empty_res   = empty_reg;

endmodule

/* rtl/core/roman_enc_ctrl.sv */
// Controller: run sequencing and output beat valid.
module roman_enc_ctrl
    import roman_enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (slot_free && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.load = 1'b0;
        cmd.emit = 1'b0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                cmd.emit = slot_free;
            end
            default: ;
        endcase
    end

    // output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/roman_numeral_encoder_unit.sv */
// Roman numeral encoder: takes a value of 0..3999 and sends its numeral one
// letter per beat, last_letter set on the final letter; a zero value gives a
// single beat with letter 0 and empty_res set. Values 4000..4095 simply carry
// on the greedy rule with a fourth M. One item occupies the block for a load
// step and then one emit step per letter (at most 15 letters), as the single
// output register takes one letter per cycle unless the output stalls. A new
// value is taken while the final letter of the previous run still waits in
// the output register.
module roman_numeral_encoder_unit
    import roman_enc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    roman_enc_value_if.sink    number,
    roman_enc_letter_if.source numeral
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    roman_enc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (number.valid),
        .in_ready  (number.ready),
        .out_valid (numeral.valid),
        .out_ready (numeral.ready),
        .status    (status),
        .cmd       (cmd)
    );

    roman_enc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value       (number.value),
        .status      (status),
        .letter      (numeral.letter),
        .last_letter (numeral.last_letter),
        .empty_res   (numeral.empty_res)
    );

endmodule

/* rtl/core/roman_enc_checker.sv */
// Port-level checks for the Roman numeral encoder, bound to the top level.
module roman_enc_checker
    import roman_enc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [LETTER_W-1:0] letter,
    input logic                last_letter,
    input logic                empty_res
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(letter)
            && $stable(last_letter) && $stable(empty_res))
        else $error("output beat changed while stalled");

    // one value at a time: busy right after a load
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken during a run");

    // a run still in flight keeps the input closed
    a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_letter |-> !in_ready)
        else $error("input open before the run ended");

    // empty beat form
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> letter == LETTER_NONE && last_letter)
        else $error("malformed empty beat");

    // letters are numeral letters
    a_letter_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_res |-> letter == LETTER_I || letter == LETTER_V
            || letter == LETTER_X || letter == LETTER_L || letter == LETTER_C
            || letter == LETTER_D || letter == LETTER_M)
        else $error("letter outside the numeral set");

endmodule

bind roman_numeral_encoder_unit roman_enc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (number.valid),
    .in_ready    (number.ready),
    .out_valid   (numeral.valid),
    .out_ready   (numeral.ready),
    .letter      (numeral.letter),
    .last_letter (numeral.last_letter),
    .empty_res   (numeral.empty_res)
);

/* tb/sv/tb_roman_numeral_encoder_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Roman numeral encoder unit.
module tb_roman_numeral_encoder_unit;
    import roman_enc_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_VALUES   = 196;
    localparam int CALM_TAIL       = 40;      // final random values sent with no idling
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 24;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DIRECTED_ROWS   = 24;
    localparam int GREEDY_STEPS    = 13;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last_letter;
        logic                empty_res;
    } numeral_beat_t;

    // One directed value; a numeral is typed in only where has_numeral is set
    typedef struct {
        logic [VALUE_W-1:0] value;
        bit                 has_numeral;
        string              numeral;
    } directed_row_t;

    // Greedy denominations, largest first, with their one or two letters
    localparam logic [VALUE_W-1:0] DENOM [GREEDY_STEPS] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };
    localparam logic [LETTER_W-1:0] DENOM_HEAD [GREEDY_STEPS] = '{
        LETTER_M, LETTER_C, LETTER_D, LETTER_C, LETTER_C, LETTER_X, LETTER_L,
        LETTER_X, LETTER_X, LETTER_I, LETTER_V, LETTER_I, LETTER_I
    };
    localparam logic [LETTER_W-1:0] DENOM_TAIL [GREEDY_STEPS] = '{
        LETTER_NONE, LETTER_M, LETTER_NONE, LETTER_D, LETTER_NONE, LETTER_C,
        LETTER_NONE, LETTER_L, LETTER_NONE, LETTER_X, LETTER_NONE, LETTER_V,
        LETTER_NONE
    };

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{12'd0,    1'b1, ""},
        '{12'd1,    1'b1, "I"},
        '{12'd3999, 1'b1, "MMMCMXCIX"},
        '{12'd3888, 1'b1, "MMMDCCCLXXXVIII"},
        '{12'd4000, 1'b1, "MMMM"},
        '{12'd4095, 1'b1, "MMMMXCV"},
        '{12'd3,    1'b0, ""},
        '{12'd4,    1'b0, ""},
        '{12'd5,    1'b0, ""},
        '{12'd9,    1'b0, ""},
        '{12'd10,   1'b0, ""},
        '{12'd40,   1'b0, ""},
        '{12'd50,   1'b0, ""},
        '{12'd90,   1'b0, ""},
        '{12'd100,  1'b0, ""},
        '{12'd400,  1'b0, ""},
        '{12'd500,  1'b0, ""},
        '{12'd900,  1'b0, ""},
        '{12'd1000, 1'b0, ""},
        '{12'd444,  1'b0, ""},
        '{12'd1994, 1'b0, ""},
        '{12'd2048, 1'b0, ""},
        '{12'd2730, 1'b0, ""},
        '{12'd1365, 1'b0, ""}
    };

    logic clk;
    logic rst_n;

    roman_enc_value_if  number_ch ();
    roman_enc_letter_if numeral_ch ();

    roman_numeral_encoder_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .number  (number_ch),
        .numeral (numeral_ch)
    );

    numeral_beat_t       pending_beats [$];
    logic [LETTER_W-1:0] run_letters [$];
    int                  error_count;
    int                  cycle_count;
    bit                  idle_on;
    bit                  hold_off_req;
    bit                  hold_off_done;

    always #HALF_PERIOD clk = ~clk;

    // Drive every input to a known level at time zero
    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        number_ch.valid   = 1'b0;
        number_ch.value   = '0;
        numeral_ch.ready  = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        idle_on           = 1'b1;
        hold_off_req      = 1'b0;
        hold_off_done     = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Greedy conversion of one value into its letters
    function automatic void roman_letters(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] rest;
        int                 k;
        rest = v;
        k    = 0;
        run_letters.delete();
        while (rest != '0 && k < GREEDY_STEPS)
        begin
            if (rest >= DENOM[k])
            begin
                rest -= DENOM[k];
                run_letters.push_back(DENOM_HEAD[k]);
                if (DENOM_TAIL[k] != LETTER_NONE)
                begin
                    run_letters.push_back(DENOM_TAIL[k]);
                end
            end
            else
            begin
                k++;
            end
        end
    endfunction

    // Typed-in numeral into letters
    function automatic void spelled_letters(input string s);
        run_letters.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            run_letters.push_back(LETTER_W'(s[i]));
        end
    endfunction

    // Queue the beats of one run; no letters means the single empty beat
    function automatic void queue_run();
        numeral_beat_t b;
        if (run_letters.size() == 0)
        begin
            b = '{letter: LETTER_NONE, last_letter: 1'b1, empty_res: 1'b1};
            pending_beats.push_back(b);
        end
        for (int i = 0; i < run_letters.size(); i++)
        begin
            b.letter      = run_letters[i];
            b.last_letter = (i == run_letters.size() - 1);
            b.empty_res   = 1'b0;
            pending_beats.push_back(b);
        end
    endfunction

    // Offer one value; returns at the falling edge after it is taken
    task automatic send_value(input logic [VALUE_W-1:0] v, input bit has_numeral,
                              input string numeral);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            number_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        number_ch.valid <= 1'b1;
        number_ch.value <= v;
        @(posedge clk);
        while (!number_ch.ready)
        begin
            @(posedge clk);
        end
        if (has_numeral)
        begin
            spelled_letters(numeral);
        end
        else
        begin
            roman_letters(v);
        end
        queue_run();
        @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            return '0;
        end
        else if (pick < 20)
        begin
            return VALUE_W'($urandom_range(4000, 4095));
        end
        else if (pick < 32)
        begin
            return VALUE_W'($urandom_range(1, 50));
        end
        return VALUE_W'($urandom_range(1, 3999));
    endfunction

    // Letter sink: random stalls, plus one long hold-off to back the block up
    initial
    begin : letter_sink
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                numeral_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                numeral_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            else
            begin
                numeral_ch.ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // Check each output beat against the oldest expectation
    always @(posedge clk)
    begin
        numeral_beat_t want;
        if (rst_n && numeral_ch.valid && numeral_ch.ready)
        begin
            if (pending_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat, letter %0d",
                                          numeral_ch.letter));
            end
            else
            begin
                want = pending_beats.pop_front();
                if (numeral_ch.letter !== want.letter)
                begin
                    report_mismatch($sformatf("letter %0d, want %0d",
                                              numeral_ch.letter, want.letter));
                end
                if (numeral_ch.last_letter !== want.last_letter)
                begin
                    report_mismatch($sformatf("last_letter %0b, want %0b",
                                              numeral_ch.last_letter, want.last_letter));
                end
                if (numeral_ch.empty_res !== want.empty_res)
                begin
                    report_mismatch($sformatf("empty_res %0b, want %0b",
                                              numeral_ch.empty_res, want.empty_res));
                end
            end
        end
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random values, drain
    initial
    begin : main_seq
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_value(directed_rows[i].value, directed_rows[i].has_numeral,
                       directed_rows[i].numeral);
        end

        for (int n = 0; n < RANDOM_VALUES; n++)
        begin
            // idling in phases, with quiet stretches and a quiet tail
            idle_on = (n < RANDOM_VALUES - CALM_TAIL) && ((n / 30) % 3 != 2);
            if (n == 10)
            begin
                hold_off_req = 1'b1;
            end
            send_value(random_value(), 1'b0, "");
        end
        number_ch.valid <= 1'b0;

        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/roman_enc_pkg.sv
rtl/core/roman_enc_value_if.sv
rtl/core/roman_enc_letter_if.sv
rtl/core/roman_enc_dp.sv
rtl/core/roman_enc_ctrl.sv
rtl/core/roman_numeral_encoder_unit.sv
rtl/core/roman_enc_checker.sv
tb/sv/tb_roman_numeral_encoder_unit.sv
